### hw/rtl/lpr_pkg.sv
// Shared constants and types for the line pixel rasterizer.
package lpr_pkg;

    localparam int SCREEN_BITS  = 11;
    localparam int CFG_IDX_BITS = 1;
    localparam int COLOUR_BITS  = 16;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;

    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RST  = 11'd320;
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RST = 11'd240;

    // Stepper status seen by the top level.
    typedef struct packed {
        logic accept;     // input transfer this cycle
        logic busy;       // a line is active
        logic at_target;  // current pixel is the second endpoint
        logic load_out;   // a pixel enters the result register
    } t_lpr_status;

endpackage

### hw/rtl/lpr_setup.sv
// Line setup: endpoint clamping, deltas, step directions and initial error.
module lpr_setup #(
    parameter int COORD_BITS = 10
) (
    input  logic [COORD_BITS-1:0]          i_start_x,
    input  logic [COORD_BITS-1:0]          i_start_y,
    input  logic [COORD_BITS-1:0]          i_end_x,
    input  logic [COORD_BITS-1:0]          i_end_y,
    input  logic [lpr_pkg::SCREEN_BITS-1:0] i_screen_width,
    input  logic [lpr_pkg::SCREEN_BITS-1:0] i_screen_height,
    output logic [COORD_BITS-1:0]          o_x0,
    output logic [COORD_BITS-1:0]          o_y0,
    output logic [COORD_BITS-1:0]          o_x1,
    output logic [COORD_BITS-1:0]          o_y1,
    output logic [COORD_BITS-1:0]          o_dcol,
    output logic [COORD_BITS-1:0]          o_drow,
    output logic [1:0]                     o_dirs,
    output logic signed [COORD_BITS+1:0]   o_err
);
    import lpr_pkg::*;

    localparam int CW = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;
    localparam int EW = COORD_BITS + 2;

    logic [SCREEN_BITS-1:0] lim_w;
    logic [SCREEN_BITS-1:0] lim_h;

    // A size of zero behaves as one.
    assign lim_w = (i_screen_width == '0)  ? '0 : i_screen_width - 1'b1;
    assign lim_h = (i_screen_height == '0) ? '0 : i_screen_height - 1'b1;

    function automatic logic [COORD_BITS-1:0] clamp(
        input logic [COORD_BITS-1:0]  v,
        input logic [SCREEN_BITS-1:0] lim
    );
        logic [COORD_BITS-1:0] res;
        if (CW'(v) > CW'(lim)) begin
            res = COORD_BITS'(lim);
        end else begin
            res = v;
        end
        return res;
    endfunction

    logic signed [EW-1:0] dc_s;
    logic signed [EW-1:0] dr_s;

    always_comb begin
        o_x0 = clamp(i_start_x, lim_w);
        o_y0 = clamp(i_start_y, lim_h);
        o_x1 = clamp(i_end_x, lim_w);
        o_y1 = clamp(i_end_y, lim_h);
        if (o_x1 >= o_x0) begin
            o_dcol    = o_x1 - o_x0;
            o_dirs[0] = 1'b0;
        end else begin
            o_dcol    = o_x0 - o_x1;
            o_dirs[0] = 1'b1;
        end
        if (o_y1 >= o_y0) begin
            o_drow    = o_y1 - o_y0;
            o_dirs[1] = 1'b0;
        end else begin
            o_drow    = o_y0 - o_y1;
            o_dirs[1] = 1'b1;
        end
        dc_s = signed'(EW'(o_dcol >> 1));
        dr_s = signed'(EW'(o_drow >> 1));
        o_err = (o_dcol > o_drow) ? dc_s : -dr_s;
    end

endmodule

### hw/rtl/lpr_stepper.sv
// Line state, error-term stepping and the pixel result register.
module lpr_stepper #(
    parameter int COORD_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_action,
    input  logic [COORD_BITS-1:0]              i_x0,
    input  logic [COORD_BITS-1:0]              i_y0,
    input  logic [COORD_BITS-1:0]              i_x1,
    input  logic [COORD_BITS-1:0]              i_y1,
    input  logic [COORD_BITS-1:0]              i_dcol,
    input  logic [COORD_BITS-1:0]              i_drow,
    input  logic [1:0]                         i_dirs,
    input  logic signed [COORD_BITS+1:0]       i_err,
    input  logic [lpr_pkg::COLOUR_BITS-1:0]    i_line_colour,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [COORD_BITS-1:0]              o_pixel_x,
    output logic [COORD_BITS-1:0]              o_pixel_y,
    output logic [lpr_pkg::COLOUR_BITS-1:0]    o_pixel_colour,
    output logic                               o_last_pixel,
    output lpr_pkg::t_lpr_status               o_status
);
    import lpr_pkg::*;

    localparam int EW = COORD_BITS + 2;

    logic                   r_busy;
    logic [COORD_BITS-1:0]  r_cur_col, r_cur_row, r_tgt_col, r_tgt_row;
    logic [COORD_BITS-1:0]  r_dcol, r_drow;
    logic [1:0]             r_dirs;
    logic signed [EW-1:0]   r_err;
    logic [COLOUR_BITS-1:0] r_colour;

    logic                   r_out_valid;
    logic [COORD_BITS-1:0]  r_out_x, r_out_y;
    logic [COLOUR_BITS-1:0] r_out_colour;
    logic                   r_out_last;

    logic                   accept, at_target, load_out, col_step, row_step;
    logic signed [EW-1:0]   dc_s, dr_s, n_err;
    logic [COORD_BITS-1:0]  n_cur_col, n_cur_row;

    // Result register frees up when its pixel transfers this cycle.
    assign o_stall  = r_out_valid & i_stall;
    assign accept   = i_valid & ~o_stall;
    assign at_target = (r_cur_col == r_tgt_col) && (r_cur_row == r_tgt_row);
    assign load_out = accept && (i_action == ACT_TICK) && r_busy;

    always_comb begin
        dc_s     = signed'(EW'(r_dcol));
        dr_s     = signed'(EW'(r_drow));
        // Both tests use the error from the start of the step.
        col_step = r_err > -dc_s;
        row_step = r_err < dr_s;
        n_err    = r_err - (col_step ? dr_s : '0) + (row_step ? dc_s : '0);
        n_cur_col = r_cur_col;
        n_cur_row = r_cur_row;
        if (col_step) begin
            n_cur_col = r_dirs[0] ? r_cur_col - 1'b1 : r_cur_col + 1'b1;
        end
        if (row_step) begin
            n_cur_row = r_dirs[1] ? r_cur_row - 1'b1 : r_cur_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && (i_action == ACT_START)) begin
                r_busy <= 1'b1;
            end else if (load_out && at_target) begin
                r_busy <= 1'b0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_action == ACT_START)) begin
            r_cur_col <= i_x0;
            r_cur_row <= i_y0;
            r_tgt_col <= i_x1;
            r_tgt_row <= i_y1;
            r_dcol    <= i_dcol;
            r_drow    <= i_drow;
            r_dirs    <= i_dirs;
            r_err     <= i_err;
            r_colour  <= i_line_colour;
        end else if (load_out && !at_target) begin
            r_cur_col <= n_cur_col;
            r_cur_row <= n_cur_row;
            r_err     <= n_err;
        end
        if (load_out) begin
            r_out_x      <= r_cur_col;
            r_out_y      <= r_cur_row;
            r_out_colour <= r_colour;
            r_out_last   <= at_target;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pixel_x      = r_out_x;
    assign o_pixel_y      = r_out_y;
    assign o_pixel_colour = r_out_colour;
    assign o_last_pixel   = r_out_last;

    always_comb begin
        o_status.accept    = accept;
        o_status.busy      = r_busy;
        o_status.at_target = at_target;
        o_status.load_out  = load_out;
    end

endmodule

### hw/rtl/line_pixel_rasterizer.sv
// Top level of the line pixel rasterizer: screen size registers and assertions.
//
// Input channel (i_valid / o_stall) carries an action and line data. A start
// action latches two endpoints, clamped to the screen size, and a colour; it
// gives no pixel. Each tick transfer while a line is active gives the next
// pixel on the output channel (o_valid / i_stall), first endpoint first; the
// second endpoint comes with o_last_pixel set and the block then goes idle.
// Ticks while idle are taken and dropped. A start during a line abandons it.
// A pixel is on o_valid in the cycle after its tick transfer.
// Throughput: one item per cycle while not stalled; the whole step is one pass
// of logic between the line state registers and the result register.
// When the receiver stalls, the result register holds and o_stall rises
// only while that register is full, so items keep flowing otherwise.
// Screen size is written through i_cfg_we / i_cfg_index / i_cfg_data; the user
// must write it only while idle; the block does not enforce it. Synchronous reset
// (i_rst_n low) drops any line and pending pixel and sets the screen to 320 by 240.
module line_pixel_rasterizer #(
    parameter int COORD_BITS = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lpr_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [lpr_pkg::SCREEN_BITS-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_action,
    input  logic [COORD_BITS-1:0]              i_start_x,
    input  logic [COORD_BITS-1:0]              i_start_y,
    input  logic [COORD_BITS-1:0]              i_end_x,
    input  logic [COORD_BITS-1:0]              i_end_y,
    input  logic [lpr_pkg::COLOUR_BITS-1:0]    i_line_colour,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [COORD_BITS-1:0]              o_pixel_x,
    output logic [COORD_BITS-1:0]              o_pixel_y,
    output logic [lpr_pkg::COLOUR_BITS-1:0]    o_pixel_colour,
    output logic                               o_last_pixel
);
    import lpr_pkg::*;

    logic [SCREEN_BITS-1:0] r_screen_width, r_screen_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [COORD_BITS-1:0]        x0, y0, x1, y1, dcol, drow;
    logic [1:0]                   dirs;
    logic signed [COORD_BITS+1:0] err0;
    t_lpr_status                  status;

    lpr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_end_x         (i_end_x),
        .i_end_y         (i_end_y),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .o_x0            (x0),
        .o_y0            (y0),
        .o_x1            (x1),
        .o_y1            (y1),
        .o_dcol          (dcol),
        .o_drow          (drow),
        .o_dirs          (dirs),
        .o_err           (err0)
    );

    lpr_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_x0           (x0),
        .i_y0           (y0),
        .i_x1           (x1),
        .i_y1           (y1),
        .i_dcol         (dcol),
        .i_drow         (drow),
        .i_dirs         (dirs),
        .i_err          (err0),
        .i_line_colour  (i_line_colour),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_colour (o_pixel_colour),
        .o_last_pixel   (o_last_pixel),
        .o_status       (status)
    );

    a_start_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.accept && i_action == ACT_START) |=> status.busy)
        else $error("line not active after start transfer");

    a_last_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.load_out && status.at_target) |=> (!status.busy && o_last_pixel))
        else $error("final pixel did not end the line");

    a_idle_tick_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (status.accept && i_action == ACT_TICK && !status.busy && !o_valid)
        |=> !o_valid)
        else $error("pixel produced by a tick while idle");

    a_pixel_has_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(status.load_out))
        else $error("pixel appeared without a tick transfer");

endmodule
